// File: design/ccb_pkg.sv
// Shared constants and types for the clipped colour-key blitter.
`default_nettype none

package ccb_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;

    localparam int COUNT_W = 9;   // column and row counters
    localparam int POS_W   = 12;  // signed screen position, dest + counter
    localparam int ADDR_W  = 16;
    localparam int COLOR_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [COUNT_W-1:0] ROW_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 3'd7;

    typedef struct packed {
        logic adv;   // a pixel beat is taken this cycle
        logic last;  // that beat ends the element
    } step_t;

endpackage

`default_nettype wire

// File: design/ccb_pixel_walker.sv
// Column and row counters that track the source pixel's place in the element.
`default_nettype none

module ccb_pixel_walker
    import ccb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire step_t              step,
    input  wire logic [COUNT_W-1:0] elem_width,
    output logic      [COUNT_W-1:0] col,
    output logic      [COUNT_W-1:0] row
);

    logic [COUNT_W-1:0] col_reg, col_next;
    logic [COUNT_W-1:0] row_reg, row_next;
    logic [COUNT_W-1:0] width_eff;
    logic [COUNT_W:0]   col_inc;

    // a width of zero behaves as one
    assign width_eff = (elem_width == '0) ? COUNT_W'(1) : elem_width;
    assign col_inc   = {1'b0, col_reg} + (COUNT_W+1)'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (step.adv) begin
            if (step.last) begin
                col_next = '0;
                row_next = '0;
            end else if (col_inc >= {1'b0, width_eff}) begin
                col_next = '0;
                if (row_reg != ROW_MAX) begin
                    row_next = row_reg + COUNT_W'(1);
                end
            end else begin
                col_next = col_inc[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;
    assign row = row_reg;

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step.adv && step.last |=> col_reg == '0 && row_reg == '0)
        else $error("counters did not restart after the last pixel");

    a_row_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        step.adv && !step.last && row_reg == ROW_MAX |=> row_reg == ROW_MAX)
        else $error("row counter wrapped past its bound");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step.adv |=> $stable(col_reg) && $stable(row_reg))
        else $error("counters moved without a pixel beat");

endmodule

`default_nettype wire

// File: design/clipped_color_key_blit_core.sv
// Top level of the clipped colour-key blitter: config registers and two-stage pipeline.
//
// Source pixels enter on the s_ channel in row-major order, one palette index per beat,
// with s_tlast on the element's final pixel. Each beat yields exactly one result beat
// on the m_ channel: m_tuser says whether the framebuffer is written, m_tdata carries
// the byte address and colour (both zero when no write), m_tlast echoes s_tlast.
// The screen point is (dest_x + column, dest_y + row); a write needs that point inside
// both the clip rectangle and the screen, and in transparent mode a nonzero colour.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data; the user must
// write it only while no pixel is in flight, as the block does not enforce this. Each
// write lands at the clock edge where cfg_wr_en is high. A taken beat moves from the
// input register into the result register once that is free. Throughput: one pixel
// per clock while the receiver does not stall, since the input register refills at
// the edge where it hands its pixel on; the counters update at the input handshake.
// When the receiver stalls, the result register holds and the input register fills
// once more, so s_tready drops only after both stages are full.
// Reset (aresetn low, synchronous) empties both stages, zeroes the counters and loads
// the register defaults: dest 0,0, width 1, clip 0,0 to 319,199, transparent off.
`default_nettype none

module clipped_color_key_blit_core
    import ccb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] pixel_color
    input  wire logic                  s_tlast,   // last_pixel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [23:0]           m_tdata,   // [15:0] write_address, [23:16] write_color
    output logic                       m_tuser,   // [0] write_enable
    output logic                       m_tlast,   // element_done
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic signed [10:0]      dest_x_reg;
    logic signed [10:0]      dest_y_reg;
    logic [COUNT_W-1:0]      elem_width_reg;
    logic [8:0]              clip_left_reg;
    logic [7:0]              clip_top_reg;
    logic [8:0]              clip_right_reg;
    logic [7:0]              clip_bottom_reg;
    logic                    transparent_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_x_reg      <= '0;
            dest_y_reg      <= '0;
            elem_width_reg  <= COUNT_W'(1);
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= 9'd319;
            clip_bottom_reg <= 8'd199;
            transparent_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DEST_X:      dest_x_reg      <= cfg_data;
                CFG_DEST_Y:      dest_y_reg      <= cfg_data;
                CFG_ELEM_WIDTH:  elem_width_reg  <= cfg_data[COUNT_W-1:0];
                CFG_CLIP_LEFT:   clip_left_reg   <= cfg_data[8:0];
                CFG_CLIP_TOP:    clip_top_reg    <= cfg_data[7:0];
                CFG_CLIP_RIGHT:  clip_right_reg  <= cfg_data[8:0];
                CFG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data[7:0];
                CFG_TRANSPARENT: transparent_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic  in_valid_reg;
    logic  m_valid_reg;
    logic  out_free;
    logic  in_adv;
    logic  s_take;
    step_t step;

    assign out_free = !m_valid_reg || m_tready;
    assign in_adv   = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_take   = s_tvalid && s_tready;

    assign step.adv  = s_take;
    assign step.last = s_tlast;

    logic [COUNT_W-1:0] col;
    logic [COUNT_W-1:0] row;

    ccb_pixel_walker u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .elem_width (elem_width_reg),
        .col        (col),
        .row        (row)
    );

    // input stage: screen position of the pixel
    logic signed [POS_W-1:0] s1_sx_reg;
    logic signed [POS_W-1:0] s1_sy_reg;
    logic [COLOR_W-1:0]      s1_color_reg;
    logic                    s1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (in_adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            s1_sx_reg    <= POS_W'(dest_x_reg) + $signed({{(POS_W-COUNT_W){1'b0}}, col});
            s1_sy_reg    <= POS_W'(dest_y_reg) + $signed({{(POS_W-COUNT_W){1'b0}}, row});
            s1_color_reg <= s_tdata[COLOR_W-1:0];
            s1_last_reg  <= s_tlast;
        end
    end

    // result stage: clip test and address
    logic              in_clip;
    logic              on_screen;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;

    // clip bounds are non-negative, so the left and top tests also reject negatives
    assign in_clip = (s1_sx_reg >= $signed({{(POS_W-9){1'b0}}, clip_left_reg}))
                  && (s1_sx_reg <= $signed({{(POS_W-9){1'b0}}, clip_right_reg}))
                  && (s1_sy_reg >= $signed({{(POS_W-8){1'b0}}, clip_top_reg}))
                  && (s1_sy_reg <= $signed({{(POS_W-8){1'b0}}, clip_bottom_reg}));
    assign on_screen = (s1_sx_reg >= 0) && (s1_sy_reg >= 0)
                    && (s1_sx_reg < $signed(POS_W'(SCREEN_WIDTH)))
                    && (s1_sy_reg < $signed(POS_W'(SCREEN_HEIGHT)));
    assign wr_en = in_clip && on_screen && !(transparent_reg && s1_color_reg == '0);
    assign addr  = ADDR_W'(s1_sy_reg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(s1_sx_reg);

    logic [ADDR_W-1:0]  m_addr_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic               m_wr_en_reg;
    logic               m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            m_wr_en_reg <= wr_en;
            m_addr_reg  <= wr_en ? addr : '0;
            m_color_reg <= wr_en ? s1_color_reg : '0;
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_color_reg, m_addr_reg};
    assign m_tuser  = m_wr_en_reg;
    assign m_tlast  = m_last_reg;

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_wr_en_reg |-> m_addr_reg == '0 && m_color_reg == '0)
        else $error("disabled write carries a nonzero address or colour");

    a_addr_in_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_wr_en_reg |-> m_addr_reg < ADDR_W'(SCREEN_WIDTH * SCREEN_HEIGHT))
        else $error("write address beyond the framebuffer");

    a_key_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_wr_en_reg && transparent_reg |-> m_color_reg != '0)
        else $error("key colour written in transparent mode");

endmodule

`default_nettype wire
